/* rtl/kspace_kinetic_phase_rotation_macros.svh */
// ============================================================================
// kinetic phase rotation assertion macros
// shared wrappers for the concurrent checks on the block's ports
// ============================================================================
`ifndef KSPACE_KINETIC_PHASE_ROTATION_MACROS_SVH
`define KSPACE_KINETIC_PHASE_ROTATION_MACROS_SVH

// same-cycle implication, off while in reset
`define KKPR_ASSERT(label, ck, rs, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define KKPR_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
        else $error(msg);

// same-cycle implication, checked during reset too
`define KKPR_ASSERT_ALWAYS(label, ck, ante, cons, msg) \
    label: assert property (@(posedge ck) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/kkpr_pkg.sv */
// ============================================================================
// kkpr_pkg
// types, widths and constant tables of the kinetic phase rotation block
// ============================================================================
`default_nettype none

package kkpr_pkg;

    // block sizing
    localparam int MAX_SIDE      = 1024;
    localparam int CORDIC_STAGES = 30;

    // field widths
    localparam int COORD_W    = 10;
    localparam int SIDE_W     = 11;
    localparam int WAVE_W     = 32;
    localparam int PHASE_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // wavenumber magnitude and k squared
    localparam int SIDE_LOG_W = $clog2(MAX_SIDE) + 1;
    localparam int MAG_W      = (SIDE_W > SIDE_LOG_W) ? SIDE_W : SIDE_LOG_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int K2_W       = SQ_W + 1;

    // rotation datapath
    localparam int GUARD_BITS = 4;
    localparam int DP_W       = WAVE_W + GUARD_BITS + 4;
    localparam int Z_W        = PHASE_W + 1;
    localparam logic [PHASE_W-1:0] OCTANT_BIAS = PHASE_W'(1) << (PHASE_W - 3);

    // gain correction, 1/K in Q0.32
    localparam int GAIN_W      = 32;
    localparam logic [GAIN_W-1:0] INV_GAIN = 32'd2608131496;
    localparam int LO_W        = 16;
    localparam int MH_W        = DP_W - LO_W;
    localparam int HI_PROD_W   = MH_W + GAIN_W;
    localparam int LO_PROD_W   = GAIN_W;
    localparam int T_W         = HI_PROD_W + 1;
    localparam int ROUND_SHIFT = LO_W + GUARD_BITS;
    localparam int R_W         = T_W - ROUND_SHIFT;
    localparam logic [T_W-1:0] ROUND_BIAS = T_W'(1) << (ROUND_SHIFT - 1);
    localparam logic [R_W-1:0] SAT_POS_MAG =
        {{(R_W - WAVE_W + 1){1'b0}}, {(WAVE_W - 1){1'b1}}};
    localparam logic [R_W-1:0] SAT_NEG_MAG = SAT_POS_MAG + R_W'(1);
    localparam logic [WAVE_W-1:0] WAVE_MAX = {1'b0, {(WAVE_W - 1){1'b1}}};
    localparam logic [WAVE_W-1:0] WAVE_MIN = {1'b1, {(WAVE_W - 1){1'b0}}};

    // arctangent of 2^-i in 2^-32 turn
    localparam logic [PHASE_W-1:0] ATAN_TURNS [0:31] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // items the block can hold at once
    localparam int FRONT_STAGES  = 3;
    localparam int BACK_EXTRA    = 3;
    localparam int PIPE_CAPACITY =
        FRONT_STAGES + FIFO_DEPTH + CORDIC_STAGES + 1 + BACK_EXTRA;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIDE_X,
        CFG_SIDE_Y,
        CFG_SIDE_Z,
        CFG_PHASE_PER_K2
    } cfg_reg_t;

    // pre-rotated sample waiting for the cordic
    typedef struct packed {
        logic signed [DP_W-1:0] x;
        logic signed [DP_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } q_entry_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

`default_nettype wire

/* rtl/kkpr_if.sv */
// ============================================================================
// kkpr channel interfaces
// valid/ready channels for input samples and rotated results
// ============================================================================
`default_nettype none

interface kkpr_sample_if
    import kkpr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [COORD_W-1:0]       coord_x;
    logic [COORD_W-1:0]       coord_y;
    logic [COORD_W-1:0]       coord_z;
    logic signed [WAVE_W-1:0] wave_re;
    logic signed [WAVE_W-1:0] wave_im;

    modport source (output valid, coord_x, coord_y, coord_z, wave_re, wave_im,
                    input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, wave_re, wave_im,
                    output ready);
endinterface

interface kkpr_result_if
    import kkpr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WAVE_W-1:0] rotated_re;
    logic signed [WAVE_W-1:0] rotated_im;

    modport source (output valid, rotated_re, rotated_im, input ready);
    modport sink   (input valid, rotated_re, rotated_im, output ready);
endinterface

`default_nettype wire

/* rtl/kkpr_front.sv */
// ============================================================================
// kkpr_front
// config registers, wavenumber fold, k squared, phase and quadrant pre-rotation
// ============================================================================
`default_nettype none

module kkpr_front
    import kkpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    kkpr_sample_if.sink           sample,
    input  fifo_status_t          fifo_st,
    output logic                  push,
    output q_entry_t              entry
);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // magnitude of the folded wavenumber
    function automatic logic [MAG_W-1:0] fold_mag(input logic [COORD_W-1:0] coord,
                                                  input logic [SIDE_W-1:0]  side);
        logic [MAG_W-1:0] n;
        logic [MAG_W-1:0] half;
        logic [MAG_W-1:0] c;
        n    = (MAG_W'(side) > MAG_W'(MAX_SIDE)) ? MAG_W'(MAX_SIDE) : MAG_W'(side);
        half = n >> 1;
        c    = MAG_W'(coord);
        if (c > half)
        begin
            fold_mag = (c >= n) ? (c - n) : (n - c);
        end
        else
        begin
            fold_mag = c;
        end
    endfunction

    logic [SIDE_W-1:0]  side_x_reg;
    logic [SIDE_W-1:0]  side_y_reg;
    logic [SIDE_W-1:0]  side_z_reg;
    logic [PHASE_W-1:0] phase_per_k2_reg;

    logic en;

    logic                     s1_vld_reg;
    logic [MAG_W-1:0]         s1_mag_x_reg;
    logic [MAG_W-1:0]         s1_mag_y_reg;
    logic [MAG_W-1:0]         s1_mag_z_reg;
    logic signed [WAVE_W-1:0] s1_re_reg;
    logic signed [WAVE_W-1:0] s1_im_reg;

    logic                     s2_vld_reg;
    logic [K2_W-1:0]          s2_k2_reg;
    logic [K2_W-1:0]          s2_k2_next;
    logic signed [WAVE_W-1:0] s2_re_reg;
    logic signed [WAVE_W-1:0] s2_im_reg;

    logic                     s3_vld_reg;
    logic [PHASE_W-1:0]       s3_phase_reg;
    logic signed [WAVE_W-1:0] s3_re_reg;
    logic signed [WAVE_W-1:0] s3_im_reg;

    logic [SQ_W-1:0]            sq_x;
    logic [SQ_W-1:0]            sq_y;
    logic [SQ_W-1:0]            sq_z;
    logic [K2_W+PHASE_W-1:0]    phase_prod;
    logic [PHASE_W-1:0]         ang;
    logic [PHASE_W-1:0]         ang_biased;
    logic [1:0]                 quad;
    logic [PHASE_W-1:0]         resid;
    logic signed [DP_W-1:0]     re_ext;
    logic signed [DP_W-1:0]     im_ext;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_x_reg       <= SIDE_W'(MAX_SIDE);
            side_y_reg       <= SIDE_W'(1);
            side_z_reg       <= SIDE_W'(1);
            phase_per_k2_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SIDE_X:       side_x_reg       <= cfg_data[SIDE_W-1:0];
                CFG_SIDE_Y:       side_y_reg       <= cfg_data[SIDE_W-1:0];
                CFG_SIDE_Z:       side_z_reg       <= cfg_data[SIDE_W-1:0];
                CFG_PHASE_PER_K2: phase_per_k2_reg <= cfg_data[PHASE_W-1:0];
                default:          ;
            endcase
        end
    end

    // pipeline moves unless the last stage is blocked by a full queue
    assign en           = !s3_vld_reg || !fifo_st.full;
    assign sample.ready = en;
    assign push         = s3_vld_reg && !fifo_st.full;

    // squares and phase
    assign sq_x       = s1_mag_x_reg * s1_mag_x_reg;
    assign sq_y       = s1_mag_y_reg * s1_mag_y_reg;
    assign sq_z       = s1_mag_z_reg * s1_mag_z_reg;
    assign s2_k2_next = K2_W'(sq_x) + K2_W'(sq_y) + K2_W'(sq_z);
    assign phase_prod = s2_k2_reg * phase_per_k2_reg;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= sample.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_x_reg <= fold_mag(sample.coord_x, side_x_reg);
            s1_mag_y_reg <= fold_mag(sample.coord_y, side_y_reg);
            s1_mag_z_reg <= fold_mag(sample.coord_z, side_z_reg);
            s1_re_reg    <= sample.wave_re;
            s1_im_reg    <= sample.wave_im;
            s2_k2_reg    <= s2_k2_next;
            s2_re_reg    <= s1_re_reg;
            s2_im_reg    <= s1_im_reg;
            s3_phase_reg <= phase_prod[PHASE_W-1:0];
            s3_re_reg    <= s2_re_reg;
            s3_im_reg    <= s2_im_reg;
        end
    end

    // negated angle, quadrant and residual
    assign ang        = PHASE_W'(0) - s3_phase_reg;
    assign ang_biased = ang + OCTANT_BIAS;
    assign quad       = ang_biased[PHASE_W-1 -: 2];
    assign resid      = ang - {quad, {(PHASE_W - 2){1'b0}}};
    assign re_ext     = {{(DP_W - WAVE_W - GUARD_BITS){s3_re_reg[WAVE_W-1]}},
                         s3_re_reg, {GUARD_BITS{1'b0}}};
    assign im_ext     = {{(DP_W - WAVE_W - GUARD_BITS){s3_im_reg[WAVE_W-1]}},
                         s3_im_reg, {GUARD_BITS{1'b0}}};

    // exact quarter-turn pre-rotation
    always_comb
    begin
        entry.z = {resid[PHASE_W-1], resid};
        case (quad)
            QUAD_0:
            begin
                entry.x = re_ext;
                entry.y = im_ext;
            end
            QUAD_1:
            begin
                entry.x = -im_ext;
                entry.y = re_ext;
            end
            QUAD_2:
            begin
                entry.x = -re_ext;
                entry.y = -im_ext;
            end
            QUAD_3:
            begin
                entry.x = im_ext;
                entry.y = -re_ext;
            end
            default:
            begin
                entry.x = re_ext;
                entry.y = im_ext;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/kkpr_fifo.sv */
// ============================================================================
// kkpr_fifo
// short register queue between the classifying front and the cordic back
// ============================================================================
`default_nettype none

module kkpr_fifo
    import kkpr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  q_entry_t     wr_data,
    input  logic         pop,
    output q_entry_t     rd_data,
    output fifo_status_t status
);

    q_entry_t               mem_reg [0:FIFO_DEPTH-1];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign status.full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/kkpr_back.sv */
// ============================================================================
// kkpr_back
// pipelined cordic rotation, gain correction, saturation and output register
// ============================================================================
`default_nettype none

module kkpr_back
    import kkpr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  q_entry_t      entry,
    input  fifo_status_t  fifo_st,
    output logic          pop,
    kkpr_result_if.source result
);

    // rounded, sign-restored and saturated result
    function automatic logic [WAVE_W-1:0] finish(input logic                 neg,
                                                 input logic [HI_PROD_W-1:0] hi,
                                                 input logic [LO_PROD_W-1:0] lo);
        logic [T_W-1:0] t;
        logic [R_W-1:0] r;
        logic [R_W-1:0] neg_r;
        t     = T_W'(hi) + T_W'(lo) + ROUND_BIAS;
        r     = t[T_W-1:ROUND_SHIFT];
        neg_r = R_W'(0) - r;
        if (neg)
        begin
            finish = (r > SAT_NEG_MAG) ? WAVE_MIN : neg_r[WAVE_W-1:0];
        end
        else
        begin
            finish = (r > SAT_POS_MAG) ? WAVE_MAX : r[WAVE_W-1:0];
        end
    endfunction

    logic en;

    // cordic stage registers, index k holds values before iteration k
    logic                   cvld_reg  [0:CORDIC_STAGES];
    logic                   cvld_next [0:CORDIC_STAGES];
    logic signed [DP_W-1:0] cx_reg    [0:CORDIC_STAGES];
    logic signed [DP_W-1:0] cx_next   [0:CORDIC_STAGES];
    logic signed [DP_W-1:0] cy_reg    [0:CORDIC_STAGES];
    logic signed [DP_W-1:0] cy_next   [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]  cz_reg    [0:CORDIC_STAGES-1];
    logic signed [Z_W-1:0]  cz_next   [0:CORDIC_STAGES-1];

    logic                   abs_vld_reg;
    logic                   abs_neg_re_reg;
    logic                   abs_neg_im_reg;
    logic [DP_W-1:0]        abs_mag_re_reg;
    logic [DP_W-1:0]        abs_mag_im_reg;
    logic signed [DP_W-1:0] xf;
    logic signed [DP_W-1:0] yf;

    logic                   mul_vld_reg;
    logic                   mul_neg_re_reg;
    logic                   mul_neg_im_reg;
    logic [HI_PROD_W-1:0]   mul_hi_re_reg;
    logic [HI_PROD_W-1:0]   mul_hi_im_reg;
    logic [LO_PROD_W-1:0]   mul_lo_re_reg;
    logic [LO_PROD_W-1:0]   mul_lo_im_reg;
    logic [HI_PROD_W-1:0]   hi_re;
    logic [HI_PROD_W-1:0]   hi_im;
    logic [LO_W+GAIN_W-1:0] lo_re_full;
    logic [LO_W+GAIN_W-1:0] lo_im_full;

    logic                   out_vld_reg;
    logic [WAVE_W-1:0]      out_re_reg;
    logic [WAVE_W-1:0]      out_im_reg;

    // whole back pipeline advances unless the output register is held
    assign en  = !out_vld_reg || result.ready;
    assign pop = en && !fifo_st.empty;

    // entry from the queue
    assign cvld_next[0] = !fifo_st.empty;
    assign cx_next[0]   = entry.x;
    assign cy_next[0]   = entry.y;
    assign cz_next[0]   = entry.z;

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_iter
        logic signed [DP_W-1:0] dx;
        logic signed [DP_W-1:0] dy;
        logic                   pos;

        assign dx  = cx_reg[i] >>> i;
        assign dy  = cy_reg[i] >>> i;
        assign pos = !cz_reg[i][Z_W-1];

        assign cvld_next[i+1] = cvld_reg[i];
        assign cx_next[i+1]   = pos ? (cx_reg[i] - dy) : (cx_reg[i] + dy);
        assign cy_next[i+1]   = pos ? (cy_reg[i] + dx) : (cy_reg[i] - dx);

        if (i < CORDIC_STAGES - 1)
        begin : g_angle
            logic signed [Z_W-1:0] step;
            assign step        = $signed({1'b0, ATAN_TURNS[i]});
            assign cz_next[i+1] = pos ? (cz_reg[i] - step) : (cz_reg[i] + step);
        end
    end

    // magnitudes and gain products
    assign xf         = cx_reg[CORDIC_STAGES];
    assign yf         = cy_reg[CORDIC_STAGES];
    assign hi_re      = abs_mag_re_reg[DP_W-1:LO_W] * INV_GAIN;
    assign hi_im      = abs_mag_im_reg[DP_W-1:LO_W] * INV_GAIN;
    assign lo_re_full = abs_mag_re_reg[LO_W-1:0] * INV_GAIN;
    assign lo_im_full = abs_mag_im_reg[LO_W-1:0] * INV_GAIN;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= CORDIC_STAGES; k++)
            begin
                cvld_reg[k] <= 1'b0;
            end
            abs_vld_reg <= 1'b0;
            mul_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k <= CORDIC_STAGES; k++)
            begin
                cvld_reg[k] <= cvld_next[k];
            end
            abs_vld_reg <= cvld_reg[CORDIC_STAGES];
            mul_vld_reg <= abs_vld_reg;
            out_vld_reg <= mul_vld_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= CORDIC_STAGES; k++)
            begin
                cx_reg[k] <= cx_next[k];
                cy_reg[k] <= cy_next[k];
            end
            for (int k = 0; k < CORDIC_STAGES; k++)
            begin
                cz_reg[k] <= cz_next[k];
            end
            abs_neg_re_reg <= xf[DP_W-1];
            abs_neg_im_reg <= yf[DP_W-1];
            abs_mag_re_reg <= xf[DP_W-1] ? (DP_W'(0) - xf) : xf;
            abs_mag_im_reg <= yf[DP_W-1] ? (DP_W'(0) - yf) : yf;
            mul_neg_re_reg <= abs_neg_re_reg;
            mul_neg_im_reg <= abs_neg_im_reg;
            mul_hi_re_reg  <= hi_re;
            mul_hi_im_reg  <= hi_im;
            mul_lo_re_reg  <= lo_re_full[LO_W+GAIN_W-1:LO_W];
            mul_lo_im_reg  <= lo_im_full[LO_W+GAIN_W-1:LO_W];
            out_re_reg     <= finish(mul_neg_re_reg, mul_hi_re_reg, mul_lo_re_reg);
            out_im_reg     <= finish(mul_neg_im_reg, mul_hi_im_reg, mul_lo_im_reg);
        end
    end

    // result channel
    assign result.valid      = out_vld_reg;
    assign result.rotated_re = out_re_reg;
    assign result.rotated_im = out_im_reg;

endmodule

`default_nettype wire

/* rtl/kspace_kinetic_phase_rotation.sv */
// ============================================================================
// kspace_kinetic_phase_rotation
// Rotates each Fourier-space sample by minus phase_per_k2 times k squared,
// where k is the grid index folded to a signed wavenumber per axis. Accepts
// one sample per clock unless the last front stage waits on a full queue,
// and returns one rotated, saturated Q2.29 sample per sample in order. A
// sample passes three front stages (fold, k squared, phase multiply), the
// queue, the 30-stage CORDIC pipeline plus its entry register, then
// magnitude, gain multiply and the output register. A four-entry queue
// sits between the front and the CORDIC pipeline; a stalled output holds the
// back pipeline while the front keeps filling the queue. Configuration
// writes take effect on the next clock and should be made while idle.
// ============================================================================
`default_nettype none

module kspace_kinetic_phase_rotation
    import kkpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    kkpr_sample_if.sink           sample,
    kkpr_result_if.source         result
);

    q_entry_t     push_data;
    q_entry_t     pop_data;
    fifo_status_t fifo_st;
    logic         push;
    logic         pop;

    // fold, k squared, phase, quarter-turn pre-rotation
    kkpr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .fifo_st   (fifo_st),
        .push      (push),
        .entry     (push_data)
    );

    // decoupling queue
    kkpr_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_data),
        .pop     (pop),
        .rd_data (pop_data),
        .status  (fifo_st)
    );

    // cordic, gain correction, output register
    kkpr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .entry   (pop_data),
        .fifo_st (fifo_st),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire

/* rtl/kkpr_checker.sv */
// ============================================================================
// kkpr_checker
// port-level checks on transfers and occupancy of the rotation block
// ============================================================================
`include "kspace_kinetic_phase_rotation_macros.svh"
`default_nettype none

module kkpr_checker
    import kkpr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              sample_valid,
    input wire logic              sample_ready,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire logic [WAVE_W-1:0] result_re,
    input wire logic [WAVE_W-1:0] result_im
);

    localparam int OCC_W = $clog2(PIPE_CAPACITY + 1) + 1;

    logic             sample_xfer;
    logic             result_xfer;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;

    assign sample_xfer = sample_valid && sample_ready;
    assign result_xfer = result_valid && result_ready;
    assign occ_next    = occ_reg + OCC_W'(sample_xfer) - OCC_W'(result_xfer);

    // items accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // stalled result holds its data
    `KKPR_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(result_re) && $stable(result_im),
        "stalled result changed")

    // no result without an outstanding sample
    `KKPR_ASSERT(a_no_extra_result, clk, rst_n, result_xfer, occ_reg != '0,
        "result transfer with nothing outstanding")

    // occupancy bounded by pipeline and queue size
    `KKPR_ASSERT(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= OCC_W'(PIPE_CAPACITY),
        "more items in flight than the block can hold")

    // nothing offered while in reset
    `KKPR_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, !result_valid,
        "result valid during reset")

endmodule

bind kspace_kinetic_phase_rotation kkpr_checker u_kkpr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_re    (result.rotated_re),
    .result_im    (result.rotated_im)
);

`default_nettype wire

/* test/tb.sv */
// ============================================================================
// tb
// Checks the kinetic phase rotation block against its own predictor of the
// wavenumber fold, k squared, phase multiply, CORDIC rotation and gain
// correction. A driver streams queued samples in random bursts and a monitor
// stalls the result channel on its own pattern. Each result is compared
// field by field with the oldest prediction. The run covers directed corner
// samples and then random phases under several grid and phase settings.
// ============================================================================
`timescale 1ns / 1ps

module tb;

    import kkpr_pkg::*;

    // one input sample and one rotated result
    typedef struct {
        logic [COORD_W-1:0]       coord_x;
        logic [COORD_W-1:0]       coord_y;
        logic [COORD_W-1:0]       coord_z;
        logic signed [WAVE_W-1:0] wave_re;
        logic signed [WAVE_W-1:0] wave_im;
    } kspace_sample_t;

    typedef struct {
        logic signed [WAVE_W-1:0] rotated_re;
        logic signed [WAVE_W-1:0] rotated_im;
    } rotated_sample_t;

    // arctangent of 2^-i in 2^-32 turn, and 1/K in Q0.32
    localparam longint ARCTAN_STEPS [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };
    localparam logic [63:0] GAIN_FIX = 64'd2608131496;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 225;
    localparam int SETTLE_CYCLES    = 60;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    cfg_reg_t       cfg_index;
    logic [31:0]    cfg_data;

    kkpr_sample_if smp ();
    kkpr_result_if res ();

    kspace_kinetic_phase_rotation u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (smp),
        .result    (res)
    );

    // settings as the block should hold them
    logic [10:0] grid_side_x = 11'd1024;
    logic [10:0] grid_side_y = 11'd1;
    logic [10:0] grid_side_z = 11'd1;
    logic [31:0] turn_per_k2 = 32'd0;

    kspace_sample_t  pending_samples [$];
    rotated_sample_t expected_rotations [$];
    kspace_sample_t  shown_sample;
    rotated_sample_t arrived_rotation;
    rotated_sample_t due_rotation;

    int mismatches = 0;
    int burst_left = 0;
    int gap_left   = 0;
    int run_left   = 0;
    int stall_left = 0;
    bit tx_steady  = 1'b0;
    bit rx_steady  = 1'b0;

    // clock and reset
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SIDE_X;
        cfg_data      = '0;
        smp.valid     = 1'b0;
        smp.coord_x   = '0;
        smp.coord_y   = '0;
        smp.coord_z   = '0;
        smp.wave_re   = '0;
        smp.wave_im   = '0;
        res.ready     = 1'b0;
        fork
            forever #5 clk = ~clk;
            begin
                repeat (11) @(posedge clk);
                rst_n <= 1'b1;
            end
        join_none
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // index folded to a signed wavenumber
    function automatic longint fold_wavenumber(logic [COORD_W-1:0] idx, logic [10:0] side);
        longint n;
        longint c;
        n = (side > MAX_SIDE) ? longint'(MAX_SIDE) : longint'(side);
        c = longint'(idx);
        if (c > (n >>> 1))
            return c - n;
        return c;
    endfunction

    // gain correction, rounding and saturation of one axis
    function automatic logic [31:0] correct_gain(longint v);
        logic        neg;
        logic [63:0] m;
        logic [63:0] t;
        logic [63:0] r;
        neg = v < 0;
        m   = neg ? -v : v;
        t   = (m >> 16) * GAIN_FIX + (((m & 64'hFFFF) * GAIN_FIX) >> 16);
        r   = (t + (64'd1 << 19)) >> 20;
        if (neg)
            return (r > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - r);
        return (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
    endfunction

    // rotation of one sample by minus the kinetic phase
    function automatic rotated_sample_t rotate_by_kinetic_phase(kspace_sample_t s);
        rotated_sample_t out;
        longint          kx;
        longint          ky;
        longint          kz;
        logic [63:0]     k2;
        logic [63:0]     prod;
        logic [31:0]     angle;
        logic [31:0]     resid;
        logic [1:0]      quad;
        longint          re;
        longint          im;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint          t;
        kx    = fold_wavenumber(s.coord_x, grid_side_x);
        ky    = fold_wavenumber(s.coord_y, grid_side_y);
        kz    = fold_wavenumber(s.coord_z, grid_side_z);
        k2    = kx * kx + ky * ky + kz * kz;
        prod  = k2 * {32'd0, turn_per_k2};
        angle = 32'd0 - prod[31:0];
        quad  = 2'((angle + 32'h2000_0000) >> 30);
        resid = angle - {quad, 30'd0};
        z     = longint'($signed(resid));
        re    = s.wave_re;
        im    = s.wave_im;
        re    = re * 16;
        im    = im * 16;
        // exact quarter turns first
        case (quad)
            2'd1:
            begin
                x = -im;
                y = re;
            end
            2'd2:
            begin
                x = -re;
                y = -im;
            end
            2'd3:
            begin
                x = im;
                y = -re;
            end
            default:
            begin
                x = re;
                y = im;
            end
        endcase
        // residual steered micro-rotations
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                t = x - dx;
                y = y + dy;
                x = t;
                z = z - ARCTAN_STEPS[i];
            end
            else
            begin
                t = x + dx;
                y = y - dy;
                x = t;
                z = z + ARCTAN_STEPS[i];
            end
        end
        out.rotated_re = correct_gain(x);
        out.rotated_im = correct_gain(y);
        return out;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
        $display("mismatch on %s at %0t: got %h, expected %h", what, $time, seen, wanted);
        mismatches++;
    endtask

    // sample driver, bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp.valid <= 1'b0;
        end
        else
        begin
            if (smp.valid && smp.ready)
                expected_rotations.push_back(rotate_by_kinetic_phase(shown_sample));
            if (!smp.valid || smp.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    smp.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    shown_sample = pending_samples.pop_front();
                    smp.valid   <= 1'b1;
                    smp.coord_x <= shown_sample.coord_x;
                    smp.coord_y <= shown_sample.coord_y;
                    smp.coord_z <= shown_sample.coord_z;
                    smp.wave_re <= shown_sample.wave_re;
                    smp.wave_im <= shown_sample.wave_im;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        if (tx_steady || $urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 12);
                    end
                end
                else
                begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and ready pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                arrived_rotation.rotated_re = res.rotated_re;
                arrived_rotation.rotated_im = res.rotated_im;
                if (expected_rotations.size() == 0)
                begin
                    flag_mismatch("unexpected transfer", arrived_rotation.rotated_re, '0);
                end
                else
                begin
                    due_rotation = expected_rotations.pop_front();
                    if (arrived_rotation.rotated_re !== due_rotation.rotated_re)
                        flag_mismatch("rotated_re", arrived_rotation.rotated_re,
                                      due_rotation.rotated_re);
                    if (arrived_rotation.rotated_im !== due_rotation.rotated_im)
                        flag_mismatch("rotated_im", arrived_rotation.rotated_im,
                                      due_rotation.rotated_im);
                end
            end
            if (rx_steady)
            begin
                res.ready <= 1'b1;
            end
            else if (run_left > 0)
            begin
                run_left--;
                res.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                run_left   = $urandom_range(0, 15);
                stall_left = $urandom_range(0, 7);
                res.ready <= 1'b0;
            end
        end
    end

    task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_SIDE_X:       grid_side_x = value[10:0];
            CFG_SIDE_Y:       grid_side_y = value[10:0];
            CFG_SIDE_Z:       grid_side_z = value[10:0];
            CFG_PHASE_PER_K2: turn_per_k2 = value;
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // side registers get junk above bit 10, which the block must drop
    task automatic apply_grid(input logic [10:0] sx, input logic [10:0] sy,
                              input logic [10:0] sz, input logic [31:0] step);
        write_register(CFG_SIDE_X, ($urandom & 32'hFFFF_F800) | sx);
        write_register(CFG_SIDE_Y, ($urandom & 32'hFFFF_F800) | sy);
        write_register(CFG_SIDE_Z, ($urandom & 32'hFFFF_F800) | sz);
        write_register(CFG_PHASE_PER_K2, step);
        repeat (2) @(posedge clk);
    endtask

    task automatic queue_sample(input int x, input int y, input int z,
                                input logic [31:0] re, input logic [31:0] im);
        kspace_sample_t s;
        s.coord_x = COORD_W'(x);
        s.coord_y = COORD_W'(y);
        s.coord_z = COORD_W'(z);
        s.wave_re = re;
        s.wave_im = im;
        pending_samples.push_back(s);
    endtask

    // sender holds off until every result is back
    task automatic wait_for_idle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || smp.valid || expected_rotations.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_coord(logic [10:0] side);
        int n;
        n = (side > MAX_SIDE) ? MAX_SIDE : int'(side);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1023;
            2:       return n / 2;
            3:       return n / 2 + 1;
            4:       return (n > 0) ? n - 1 : 0;
            5:       return $urandom_range(0, 1023);
            default: return (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic logic [31:0] pick_wave();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'd0;
            3:       return 32'($urandom_range(0, 2047)) - 32'd1024;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [10:0] pick_side();
        case ($urandom_range(0, 7))
            0:       return 11'd1;
            1:       return 11'd2;
            2:       return 11'd1024;
            3:       return 11'd0;
            4:       return 11'(2 * $urandom_range(0, 511) + 1);
            5:       return 11'($urandom_range(1025, 2047));
            default: return 11'(2 * $urandom_range(1, 512));
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return 32'($urandom_range(1, 4096));
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial
    begin
        @(posedge rst_n);
        repeat (2) @(posedge clk);

        // reset settings: zero phase, only gain and saturation act
        queue_sample(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_sample(0, 0, 0, 32'h8000_0000, 32'h8000_0000);
        queue_sample(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_sample(0, 0, 0, 32'd0, 32'd0);
        queue_sample(1023, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_for_idle();

        // quarter turn per k2 hits every quadrant exactly
        apply_grid(11'd8, 11'd8, 11'd8, 32'h4000_0000);
        queue_sample(0, 0, 0, 32'h2000_0000, 32'hE000_0000);
        queue_sample(1, 0, 0, 32'h2000_0000, 32'hE000_0000);
        queue_sample(1, 1, 0, 32'h2000_0000, 32'hE000_0000);
        queue_sample(1, 1, 1, 32'h2000_0000, 32'hE000_0000);
        queue_sample(4, 0, 0, 32'h7FFF_FFFF, 32'h0000_0001);
        queue_sample(5, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_sample(7, 7, 7, 32'h1234_5678, 32'h8765_4321);
        wait_for_idle();

        // zero side, odd side, side beyond the maximum, index not below side
        apply_grid(11'd0, 11'd7, 11'd2047, 32'h2000_0001);
        queue_sample(1023, 6, 1023, 32'h2000_0000, 32'h2000_0000);
        queue_sample(5, 3, 4, 32'h8000_0000, 32'h0000_0000);
        queue_sample(9, 4, 600, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_sample(0, 1023, 512, 32'hFFFF_FFFF, 32'h0000_0001);
        queue_sample(1, 8, 513, 32'h4000_0000, 32'hC000_0000);
        wait_for_idle();

        // largest grid and phase step
        apply_grid(11'd1024, 11'd1024, 11'd1024, 32'hFFFF_FFFF);
        queue_sample(512, 512, 512, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_sample(513, 1023, 0, $urandom, $urandom);
        queue_sample(1023, 1023, 1023, 32'h8000_0000, 32'h8000_0000);
        queue_sample(511, 0, 1, $urandom, $urandom);
        wait_for_idle();

        // random phases under changing settings and idling styles
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                apply_grid(11'd1024, 11'd1024, 11'd1024, $urandom);
            else if (p == 1)
                apply_grid(11'd1, 11'd1, 11'd1, 32'd0);
            else
                apply_grid(pick_side(), pick_side(), pick_side(), pick_step());
            tx_steady = (p == 2);
            rx_steady = (p == 2) || (p == 5);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_sample(pick_coord(grid_side_x), pick_coord(grid_side_y),
                             pick_coord(grid_side_z), pick_wave(), pick_wave());
            wait_for_idle();
        end

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* kspace_kinetic_phase_rotation.f */
+incdir+rtl
rtl/kkpr_pkg.sv
rtl/kkpr_if.sv
rtl/kkpr_front.sv
rtl/kkpr_fifo.sv
rtl/kkpr_back.sv
rtl/kspace_kinetic_phase_rotation.sv
rtl/kkpr_checker.sv
test/tb.sv
